[rtl/csvft_pkg.sv]
// shared types, constants and character helpers for the csv field splitter
`timescale 1ns / 1ps
package csvft_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] WS_SPACE = 2'd0;
  localparam logic [1:0] WS_TAB   = 2'd1;
  localparam logic [1:0] WS_CR    = 2'd2;
  localparam logic [1:0] WS_LF    = 2'd3;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2,
    KIND_QUOTE_ERR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_END,
    ACT_EMIT,
    ACT_FLUSH
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND,
    ST_LAST
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load_end;
    logic load_emit;
    logic load_ws;
    logic load_hold;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic ws_last;
    logic out_free;
  } sts_t;

  function automatic logic ws_hit(input logic [7:0] c);
    ws_hit = c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

  function automatic logic [1:0] ws_code(input logic [7:0] c);
    case (c)
      CH_TAB:  ws_code = WS_TAB;
      CH_CR:   ws_code = WS_CR;
      CH_LF:   ws_code = WS_LF;
      default: ws_code = WS_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] ws_char(input logic [1:0] code);
    case (code)
      WS_TAB:  ws_char = CH_TAB;
      WS_CR:   ws_char = CH_CR;
      WS_LF:   ws_char = CH_LF;
      default: ws_char = CH_SPACE;
    endcase
  endfunction

endpackage

[rtl/csv_field_splitter_trim.sv]
// top level of the csv field splitter with whitespace trimming
//
// Input channel: one transaction per line byte (data_byte_i) or an end-of-line
// marker (line_end_i high). Output channel: one transaction per result; a field
// content byte, a field end, a field and row end, or an unterminated quote error.
// last_of_run_o marks the final result caused by an input transaction; a
// transaction that only moves quote or whitespace state gives no result.
// Latency: a field end or a content byte with no held whitespace is presented the
// cycle after its input is accepted; a flush presents its first held byte once the
// ST_READ and ST_SEND states have passed. Throughput: one input per cycle while the
// receiver takes results and no held whitespace is being flushed. A content byte
// after held whitespace bytes takes the accepting cycle, a registered read of the
// whitespace ram and an output load per held byte, and a load of the content byte;
// input is stalled meanwhile. Input is also stalled while the output register holds
// a result the receiver is stalling. Output valid and payload hold under stall.
// Reset clears quote and field state and output valid; the whitespace ram needs
// no clearing, only entries written in the current run are read.
`timescale 1ns / 1ps
module csv_field_splitter_trim #(
  parameter int WS_BUFFER_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       ws_dropped_o,
  output logic       last_of_run_o
);
  import csvft_pkg::*;

  cmd_t cmd;
  sts_t sts;

  csvft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csvft_dp #(
    .WS_BUFFER_DEPTH (WS_BUFFER_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .line_end_i    (line_end_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .ws_dropped_o  (ws_dropped_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

[rtl/csvft_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module csvft_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/csvft_dp.sv]
// datapath: quote and field state, whitespace buffer, output register
`timescale 1ns / 1ps
module csvft_dp #(
  parameter int WS_BUFFER_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         data_byte_i,
  input  logic               line_end_i,
  input  csvft_pkg::cmd_t    cmd_i,
  output csvft_pkg::sts_t    sts_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic [1:0]         kind_o,
  output logic               ws_dropped_o,
  output logic               last_of_run_o
);
  import csvft_pkg::*;

  localparam int CntW  = $clog2(WS_BUFFER_DEPTH + 1);
  localparam int AddrW = (WS_BUFFER_DEPTH > 1) ? $clog2(WS_BUFFER_DEPTH) : 1;

  logic            inside_q, inside_d;
  logic            qpend_q, qpend_d;
  logic            has_content_q, has_content_d;
  logic [CntW-1:0] count_q, count_d;
  logic            overflow_q, overflow_d;
  logic            run_lost_q, run_lost_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [7:0]      hold_q;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  kind_e           kind_q, kind_d;
  logic            dropped_q, dropped_d;
  logic            last_q, last_d;

  logic            is_quote, is_comma, lit_quote, content, is_ws, is_end;
  logic            buf_full, ram_we;
  logic [1:0]      ram_rdata;
  kind_e           end_kind;
  logic            end_drop;
  act_e            act;

  always_comb begin
    is_quote  = (data_byte_i == CH_QUOTE);
    is_comma  = (data_byte_i == CH_COMMA);
    lit_quote = !line_end_i && qpend_q && is_quote;
    content   = lit_quote ||
                (!line_end_i && !is_quote && (inside_q || !is_comma));
    is_ws     = content && ws_hit(data_byte_i);
    is_end    = line_end_i || (!lit_quote && !inside_q && is_comma);
    buf_full  = (count_q >= CntW'(WS_BUFFER_DEPTH));
    ram_we    = cmd_i.accept && is_ws && has_content_q && !buf_full;
    end_kind  = line_end_i ? (inside_q ? KIND_QUOTE_ERR : KIND_ROW_END) : KIND_FIELD_END;
    end_drop  = (line_end_i && inside_q) ? 1'b0 : overflow_q;
    if (is_end) begin
      act = ACT_END;
    end else if (content && !is_ws) begin
      act = (count_q == '0) ? ACT_EMIT : ACT_FLUSH;
    end else begin
      act = ACT_NONE;
    end
  end

  assign sts_o.act      = act;
  assign sts_o.ws_last  = ((idx_q + CntW'(1)) == count_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // field and quote state
  always_comb begin
    inside_d      = inside_q;
    qpend_d       = qpend_q;
    has_content_d = has_content_q;
    count_d       = count_q;
    overflow_d    = overflow_q;
    run_lost_d    = run_lost_q;
    idx_d         = idx_q;
    if (cmd_i.accept) begin
      idx_d   = '0;
      qpend_d = !line_end_i && !lit_quote && inside_q && is_quote;
      if (line_end_i) begin
        inside_d = 1'b0;
      end else if (lit_quote) begin
        inside_d = 1'b1;
      end else if (is_quote) begin
        inside_d = !inside_q;
      end
      if (is_end) begin
        has_content_d = 1'b0;
        count_d       = '0;
        overflow_d    = 1'b0;
        run_lost_d    = 1'b0;
      end else if (is_ws) begin
        if (has_content_q) begin
          if (!buf_full) begin
            count_d = count_q + CntW'(1);
          end else begin
            run_lost_d = 1'b1;
          end
        end
      end else if (content) begin
        overflow_d    = overflow_q | run_lost_q;
        run_lost_d    = 1'b0;
        has_content_d = 1'b1;
      end
    end
    if (cmd_i.load_ws) begin
      idx_d = idx_q + CntW'(1);
    end
    if (cmd_i.load_hold) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q      <= 1'b0;
      qpend_q       <= 1'b0;
      has_content_q <= 1'b0;
      count_q       <= '0;
      overflow_q    <= 1'b0;
      run_lost_q    <= 1'b0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      inside_q      <= inside_d;
      qpend_q       <= qpend_d;
      has_content_q <= has_content_d;
      count_q       <= count_d;
      overflow_q    <= overflow_d;
      run_lost_q    <= run_lost_d;
      idx_q         <= idx_d;
      out_valid_q   <= out_valid_d;
    end
  end

  csvft_ram #(
    .WIDTH (2),
    .DEPTH (WS_BUFFER_DEPTH)
  ) u_ws_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (ws_code(data_byte_i)),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    kind_d      = kind_q;
    dropped_d   = dropped_q;
    last_d      = last_q;
    if (cmd_i.load_end) begin
      out_valid_d = 1'b1;
      out_byte_d  = 8'h00;
      kind_d      = end_kind;
      dropped_d   = end_drop;
      last_d      = 1'b1;
    end else if (cmd_i.load_emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = data_byte_i;
      kind_d      = KIND_BYTE;
      dropped_d   = 1'b0;
      last_d      = 1'b1;
    end else if (cmd_i.load_ws) begin
      out_valid_d = 1'b1;
      out_byte_d  = ws_char(ram_rdata);
      kind_d      = KIND_BYTE;
      dropped_d   = 1'b0;
      last_d      = 1'b0;
    end else if (cmd_i.load_hold) begin
      out_valid_d = 1'b1;
      out_byte_d  = hold_q;
      kind_d      = KIND_BYTE;
      dropped_d   = 1'b0;
      last_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hold_q <= data_byte_i;
    end
    out_byte_q <= out_byte_d;
    kind_q     <= kind_d;
    dropped_q  <= dropped_d;
    last_q     <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign kind_o        = kind_q;
  assign ws_dropped_o  = dropped_q;
  assign last_of_run_o = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(WS_BUFFER_DEPTH))
    else $error("whitespace count beyond buffer depth");

  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q != KIND_BYTE) |-> (out_byte_q == 8'h00) && last_q)
    else $error("end result with payload byte or not last");

  a_drop_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ((kind_q == KIND_BYTE) || (kind_q == KIND_QUOTE_ERR)) |-> !dropped_q)
    else $error("ws_dropped set on byte or quote error");

  a_qpend_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qpend_q |-> !inside_q)
    else $error("pending quote while inside quotes");

endmodule

[rtl/csvft_ctrl.sv]
// controller: accept, whitespace flush sequencing and output loads
`timescale 1ns / 1ps
module csvft_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  csvft_pkg::sts_t sts_i,
  output csvft_pkg::cmd_t cmd_o
);
  import csvft_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = !sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.accept = 1'b1;
          case (sts_i.act)
            ACT_END:   cmd_o.load_end = 1'b1;
            ACT_EMIT:  cmd_o.load_emit = 1'b1;
            ACT_FLUSH: state_d = ST_READ;
            default:   ;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SEND;
      end
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.load_ws = 1'b1;
          state_d       = sts_i.ws_last ? ST_LAST : ST_READ;
        end
      end
      ST_LAST: begin
        if (sts_i.out_free) begin
          cmd_o.load_hold = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
